// ===== rtl/core/lca_pkg.sv =====
// Shared types, codes and constants for the binary-lifting LCA block.
`default_nettype none

package lca_pkg;

    localparam int NODE_W  = 10;
    localparam int DEPTH_W = 10;
    localparam int RED_CW  = $clog2(NODE_W);

    localparam logic CMD_ATTACH = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RED,
        S_DISP,
        S_ROOT,
        S_ATT_DRD,
        S_ATT_DWR,
        S_ATT_RD,
        S_ATT_WR,
        S_Q_DA,
        S_Q_DB,
        S_Q_DCAP,
        S_LB_CHK,
        S_LB_CAP,
        S_LB_DCAP,
        S_EQ,
        S_LT_RA,
        S_LT_RB,
        S_LT_CAP,
        S_FIN_RD,
        S_FIN_CAP,
        S_OUT
    } lca_state_t;

    typedef enum logic [2:0] {
        LV_HOLD,
        LV_ZERO,
        LV_TOP,
        LV_INC,
        LV_DEC
    } lvl_op_t;

    typedef enum logic [1:0] {
        DR_A,
        DR_B,
        DR_TDATA
    } dep_rsel_t;

    typedef enum logic [1:0] {
        TR_A,
        TR_B,
        TR_CUR
    } tab_rsel_t;

    typedef enum logic [1:0] {
        TW_PARENT,
        TW_SELF,
        TW_RDATA
    } tab_wsel_t;

    typedef struct packed {
        logic      load;
        logic      red_step;
        logic      xfer;
        lvl_op_t   lvl_op;
        dep_rsel_t d_rsel;
        logic      d_we;
        logic      d_wzero;
        tab_rsel_t t_rsel;
        logic      t_rlvl_m1;
        logic      t_we;
        tab_wsel_t t_wsel;
        logic      cur_parent;
        logic      cur_rdata;
        logic      da_cap;
        logic      db_order;
        logic      b_lift;
        logic      db_cap;
        logic      pa_cap;
        logic      pair_step;
        logic      res_a;
        logic      res_rdata;
        logic      out_load;
    } lca_cmd_t;

    typedef struct packed {
        logic cmd_query;
        logic same_node;
        logic red_last;
        logic lvl_zero;
        logic lvl_top;
        logic lift_take;
        logic nodes_eq;
        logic out_free;
    } lca_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/lca_datapath.sv =====
// Datapath: node registers, depth and ancestor memories, output register.
`default_nettype none

module lca_datapath #(
    parameter int MAX_NODES = 1024,
    parameter int TOP_LEVEL = 10
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       command,
    input  wire logic [lca_pkg::NODE_W-1:0] node_a,
    input  wire logic [lca_pkg::NODE_W-1:0] node_b,
    input  wire logic                       out_stall,
    output logic                            out_valid,
    output logic [lca_pkg::NODE_W-1:0]      ancestor,
    input  wire lca_pkg::lca_cmd_t          cmd,
    output lca_pkg::lca_sts_t               sts
);

    localparam int NW     = $clog2(MAX_NODES);
    localparam int LEVELS = TOP_LEVEL + 1;
    localparam int LW     = $clog2(LEVELS);
    localparam int TSZ    = MAX_NODES * LEVELS;
    localparam int TAW    = $clog2(TSZ);
    localparam int RW     = NW + lca_pkg::NODE_W + 1;
    localparam int PW     = TOP_LEVEL + 1;
    localparam int CW     = PW + lca_pkg::DEPTH_W;
    localparam int DW     = lca_pkg::DEPTH_W;
    localparam int VW     = lca_pkg::NODE_W;
    localparam int RCW    = lca_pkg::RED_CW;

    logic [DW-1:0] depth_mem [MAX_NODES];
    logic [NW-1:0] anc_mem   [TSZ];

    logic                      cmd_q_reg, cmd_q_next;
    logic [VW-1:0]             ra_reg, ra_next, rb_reg, rb_next;
    logic [RCW-1:0]            red_cnt_reg, red_cnt_next;
    logic [NW-1:0]             a_reg, a_next, b_reg, b_next;
    logic [NW-1:0]             cur_reg, cur_next, pa_reg, pa_next, res_reg, res_next;
    logic [DW-1:0]             da_reg, da_next, db_reg, db_next;
    logic [LW-1:0]             lvl_reg, lvl_next;
    logic [DW-1:0]             d_rdata_reg;
    logic [NW-1:0]             t_rdata_reg;
    logic                      out_valid_reg, out_valid_next;
    logic [VW-1:0]             anc_reg, anc_next;

    logic [RW-1:0]  red_thr;
    logic [VW-1:0]  ra_red, rb_red;
    logic [LW-1:0]  lvl_m1, t_rlvl;
    logic [NW-1:0]  t_rnode, t_wdata, d_raddr;
    logic [TAW-1:0] t_raddr, t_waddr;
    logic [DW-1:0]  d_inc, d_wdata, gap;
    logic [PW-1:0]  pow;
    logic           order_swap;

    // one restoring step of the reduction modulo MAX_NODES
    assign red_thr = RW'(MAX_NODES) << red_cnt_reg;
    assign ra_red  = (RW'(ra_reg) >= red_thr) ? ra_reg - red_thr[VW-1:0] : ra_reg;
    assign rb_red  = (RW'(rb_reg) >= red_thr) ? rb_reg - red_thr[VW-1:0] : rb_reg;

    assign lvl_m1 = lvl_reg - LW'(1);
    assign t_rlvl = cmd.t_rlvl_m1 ? lvl_m1 : lvl_reg;

    always_comb
    begin
        case (cmd.t_rsel)
            lca_pkg::TR_A:   t_rnode = a_reg;
            lca_pkg::TR_B:   t_rnode = b_reg;
            lca_pkg::TR_CUR: t_rnode = cur_reg;
            default:         t_rnode = a_reg;
        endcase
        case (cmd.t_wsel)
            lca_pkg::TW_PARENT: t_wdata = b_reg;
            lca_pkg::TW_SELF:   t_wdata = a_reg;
            lca_pkg::TW_RDATA:  t_wdata = t_rdata_reg;
            default:            t_wdata = t_rdata_reg;
        endcase
        case (cmd.d_rsel)
            lca_pkg::DR_A:     d_raddr = a_reg;
            lca_pkg::DR_B:     d_raddr = b_reg;
            lca_pkg::DR_TDATA: d_raddr = t_rdata_reg;
            default:           d_raddr = a_reg;
        endcase
    end

    // row-major: entry (node, level) at node * LEVELS + level
    assign t_raddr = TAW'(t_rnode) * TAW'(LEVELS) + TAW'(t_rlvl);
    assign t_waddr = TAW'(a_reg) * TAW'(LEVELS) + TAW'(lvl_reg);

    // child depth saturates
    assign d_inc   = (d_rdata_reg == '1) ? d_rdata_reg : d_rdata_reg + DW'(1);
    assign d_wdata = cmd.d_wzero ? '0 : d_inc;

    assign gap        = db_reg - da_reg;
    assign pow        = PW'(1) << lvl_reg;
    assign order_swap = da_reg > d_rdata_reg;

    always_comb
    begin
        cmd_q_next     = cmd_q_reg;
        ra_next        = ra_reg;
        rb_next        = rb_reg;
        red_cnt_next   = red_cnt_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        cur_next       = cur_reg;
        pa_next        = pa_reg;
        res_next       = res_reg;
        da_next        = da_reg;
        db_next        = db_reg;
        lvl_next       = lvl_reg;
        anc_next       = anc_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (cmd.load)
        begin
            cmd_q_next   = command;
            ra_next      = node_a;
            rb_next      = node_b;
            red_cnt_next = RCW'(VW - 1);
        end
        if (cmd.red_step)
        begin
            ra_next      = ra_red;
            rb_next      = rb_red;
            red_cnt_next = red_cnt_reg - RCW'(1);
        end
        if (cmd.xfer)
        begin
            a_next = NW'(ra_reg);
            b_next = NW'(rb_reg);
        end
        if (cmd.cur_parent)
            cur_next = b_reg;
        if (cmd.cur_rdata)
            cur_next = t_rdata_reg;
        if (cmd.da_cap)
            da_next = d_rdata_reg;
        if (cmd.db_order)
        begin
            if (order_swap)
            begin
                a_next  = b_reg;
                b_next  = a_reg;
                da_next = d_rdata_reg;
                db_next = da_reg;
            end
            else
                db_next = d_rdata_reg;
        end
        if (cmd.b_lift)
            b_next = t_rdata_reg;
        if (cmd.db_cap)
            db_next = d_rdata_reg;
        if (cmd.pa_cap)
            pa_next = t_rdata_reg;
        if (cmd.pair_step && (pa_reg != t_rdata_reg))
        begin
            a_next = pa_reg;
            b_next = t_rdata_reg;
        end
        if (cmd.res_a)
            res_next = a_reg;
        if (cmd.res_rdata)
            res_next = t_rdata_reg;
        if (cmd.out_load)
        begin
            anc_next       = VW'(res_reg);
            out_valid_next = 1'b1;
        end

        unique case (cmd.lvl_op)
            lca_pkg::LV_HOLD: lvl_next = lvl_reg;
            lca_pkg::LV_ZERO: lvl_next = '0;
            lca_pkg::LV_TOP:  lvl_next = LW'(TOP_LEVEL);
            lca_pkg::LV_INC:  lvl_next = lvl_reg + LW'(1);
            lca_pkg::LV_DEC:  lvl_next = lvl_m1;
            default:          lvl_next = lvl_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            lvl_reg       <= '0;
            red_cnt_reg   <= '0;
            cmd_q_reg     <= lca_pkg::CMD_ATTACH;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            lvl_reg       <= lvl_next;
            red_cnt_reg   <= red_cnt_next;
            cmd_q_reg     <= cmd_q_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ra_reg  <= ra_next;
        rb_reg  <= rb_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        cur_reg <= cur_next;
        pa_reg  <= pa_next;
        res_reg <= res_next;
        da_reg  <= da_next;
        db_reg  <= db_next;
        anc_reg <= anc_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.d_we)
            depth_mem[a_reg] <= d_wdata;
        d_rdata_reg <= depth_mem[d_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.t_we)
            anc_mem[t_waddr] <= t_wdata;
        t_rdata_reg <= anc_mem[t_raddr];
    end

    assign sts.cmd_query = (cmd_q_reg == lca_pkg::CMD_QUERY);
    assign sts.same_node = (ra_reg == rb_reg);
    assign sts.red_last  = (red_cnt_reg == '0) || (MAX_NODES >= (1 << VW));
    assign sts.lvl_zero  = (lvl_reg == '0);
    assign sts.lvl_top   = (lvl_reg == LW'(TOP_LEVEL));
    assign sts.lift_take = (db_reg >= da_reg) && (CW'(gap) >= CW'(pow));
    assign sts.nodes_eq  = (a_reg == b_reg);
    assign sts.out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign ancestor  = anc_reg;

endmodule

`default_nettype wire

// ===== rtl/core/lca_controller.sv =====
// Sequencer for attach and query: drives datapath commands from status.
`default_nettype none

module lca_controller (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire lca_pkg::lca_sts_t sts,
    output lca_pkg::lca_cmd_t      cmd
);

    lca_pkg::lca_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lca_pkg::S_IDLE:
                if (in_valid)
                    state_next = lca_pkg::S_RED;
            lca_pkg::S_RED:
                if (sts.red_last)
                    state_next = lca_pkg::S_DISP;
            lca_pkg::S_DISP:
                if (sts.cmd_query)
                    state_next = lca_pkg::S_Q_DA;
                else if (sts.same_node)
                    state_next = lca_pkg::S_ROOT;
                else
                    state_next = lca_pkg::S_ATT_DRD;
            lca_pkg::S_ROOT:
                if (sts.lvl_top)
                    state_next = lca_pkg::S_IDLE;
            lca_pkg::S_ATT_DRD: state_next = lca_pkg::S_ATT_DWR;
            lca_pkg::S_ATT_DWR: state_next = lca_pkg::S_ATT_RD;
            lca_pkg::S_ATT_RD:  state_next = lca_pkg::S_ATT_WR;
            lca_pkg::S_ATT_WR:
                state_next = sts.lvl_top ? lca_pkg::S_IDLE : lca_pkg::S_ATT_RD;
            lca_pkg::S_Q_DA:    state_next = lca_pkg::S_Q_DB;
            lca_pkg::S_Q_DB:    state_next = lca_pkg::S_Q_DCAP;
            lca_pkg::S_Q_DCAP:  state_next = lca_pkg::S_LB_CHK;
            lca_pkg::S_LB_CHK:
                if (sts.lift_take)
                    state_next = lca_pkg::S_LB_CAP;
                else if (sts.lvl_zero)
                    state_next = lca_pkg::S_EQ;
            lca_pkg::S_LB_CAP:  state_next = lca_pkg::S_LB_DCAP;
            lca_pkg::S_LB_DCAP:
                state_next = sts.lvl_zero ? lca_pkg::S_EQ : lca_pkg::S_LB_CHK;
            lca_pkg::S_EQ:
                state_next = sts.nodes_eq ? lca_pkg::S_OUT : lca_pkg::S_LT_RA;
            lca_pkg::S_LT_RA:   state_next = lca_pkg::S_LT_RB;
            lca_pkg::S_LT_RB:   state_next = lca_pkg::S_LT_CAP;
            lca_pkg::S_LT_CAP:
                state_next = sts.lvl_zero ? lca_pkg::S_FIN_RD : lca_pkg::S_LT_RA;
            lca_pkg::S_FIN_RD:  state_next = lca_pkg::S_FIN_CAP;
            lca_pkg::S_FIN_CAP: state_next = lca_pkg::S_OUT;
            lca_pkg::S_OUT:
                if (sts.out_free)
                    state_next = lca_pkg::S_IDLE;
            default:            state_next = lca_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = (state_reg != lca_pkg::S_IDLE);
        unique case (state_reg)
            lca_pkg::S_IDLE:
                cmd.load = in_valid;
            lca_pkg::S_RED:
                cmd.red_step = 1'b1;
            lca_pkg::S_DISP:
            begin
                cmd.xfer   = 1'b1;
                cmd.lvl_op = lca_pkg::LV_ZERO;
            end
            lca_pkg::S_ROOT:
            begin
                cmd.d_we    = 1'b1;
                cmd.d_wzero = 1'b1;
                cmd.t_we    = 1'b1;
                cmd.t_wsel  = lca_pkg::TW_SELF;
                cmd.lvl_op  = lca_pkg::LV_INC;
            end
            lca_pkg::S_ATT_DRD:
                cmd.d_rsel = lca_pkg::DR_B;
            lca_pkg::S_ATT_DWR:
            begin
                cmd.d_we       = 1'b1;
                cmd.t_we       = 1'b1;
                cmd.t_wsel     = lca_pkg::TW_PARENT;
                cmd.cur_parent = 1'b1;
                cmd.lvl_op     = lca_pkg::LV_INC;
            end
            lca_pkg::S_ATT_RD:
            begin
                cmd.t_rsel    = lca_pkg::TR_CUR;
                cmd.t_rlvl_m1 = 1'b1;
            end
            lca_pkg::S_ATT_WR:
            begin
                cmd.t_we      = 1'b1;
                cmd.t_wsel    = lca_pkg::TW_RDATA;
                cmd.cur_rdata = 1'b1;
                cmd.lvl_op    = lca_pkg::LV_INC;
            end
            lca_pkg::S_Q_DA:
                cmd.d_rsel = lca_pkg::DR_A;
            lca_pkg::S_Q_DB:
            begin
                cmd.d_rsel = lca_pkg::DR_B;
                cmd.da_cap = 1'b1;
            end
            lca_pkg::S_Q_DCAP:
            begin
                cmd.db_order = 1'b1;
                cmd.lvl_op   = lca_pkg::LV_TOP;
            end
            lca_pkg::S_LB_CHK:
            begin
                cmd.t_rsel = lca_pkg::TR_B;
                if (!sts.lift_take && !sts.lvl_zero)
                    cmd.lvl_op = lca_pkg::LV_DEC;
            end
            lca_pkg::S_LB_CAP:
            begin
                cmd.b_lift = 1'b1;
                cmd.d_rsel = lca_pkg::DR_TDATA;
            end
            lca_pkg::S_LB_DCAP:
            begin
                cmd.db_cap = 1'b1;
                if (!sts.lvl_zero)
                    cmd.lvl_op = lca_pkg::LV_DEC;
            end
            lca_pkg::S_EQ:
            begin
                cmd.res_a  = sts.nodes_eq;
                cmd.lvl_op = lca_pkg::LV_TOP;
            end
            lca_pkg::S_LT_RA:
                cmd.t_rsel = lca_pkg::TR_A;
            lca_pkg::S_LT_RB:
            begin
                cmd.t_rsel = lca_pkg::TR_B;
                cmd.pa_cap = 1'b1;
            end
            lca_pkg::S_LT_CAP:
            begin
                cmd.pair_step = 1'b1;
                if (!sts.lvl_zero)
                    cmd.lvl_op = lca_pkg::LV_DEC;
            end
            lca_pkg::S_FIN_RD:
                cmd.t_rsel = lca_pkg::TR_A;
            lca_pkg::S_FIN_CAP:
                cmd.res_rdata = 1'b1;
            lca_pkg::S_OUT:
                cmd.out_load = sts.out_free;
            default:
                cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lca_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/tree_lca_binary_lifting.sv =====
// Top level: lowest common ancestor by binary lifting over a stored tree.
`default_nettype none

// The block keeps a tree of up to MAX_NODES nodes and answers lowest-common-ancestor
// queries. A beat with command 0 attaches node_a under node_b (node_b equal to node_a
// makes a root of depth zero); the parent must be attached first. A beat with command 1
// queries node_a and node_b and yields one ancestor beat; attach beats yield none.
// Node numbers of MAX_NODES or more are reduced modulo MAX_NODES. Depth and ancestor
// storage is not cleared at reset: naming a node never attached gives an undefined
// answer. One item is in work at a time and in_stall stays high until it is done; a
// finished answer waits in the output register while the next beat is taken.
// Reduction takes one step when MAX_NODES >= 1024, else 10 reduction steps. A query
// lifts the deeper node toward equal depth, then climbs both nodes together level by
// level; it skips that climb when the lifted nodes meet. A query answer may also wait
// for the previous answer to leave the output register.
// Every lifting level is a dependent read of the ancestor memory, which has a single
// read port with registered data; that memory port sets the rate.

module tree_lca_binary_lifting #(
    parameter int MAX_NODES = 1024,
    parameter int TOP_LEVEL = 10
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic                       command,
    input  wire logic [lca_pkg::NODE_W-1:0] node_a,
    input  wire logic [lca_pkg::NODE_W-1:0] node_b,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [lca_pkg::NODE_W-1:0]      ancestor
);

    // command and status between sequencer and datapath
    lca_pkg::lca_cmd_t ctl_cmd;
    lca_pkg::lca_sts_t dp_sts;

    lca_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (dp_sts),
        .cmd      (ctl_cmd)
    );

    lca_datapath #(
        .MAX_NODES (MAX_NODES),
        .TOP_LEVEL (TOP_LEVEL)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .command   (command),
        .node_a    (node_a),
        .node_b    (node_b),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .ancestor  (ancestor),
        .cmd       (ctl_cmd),
        .sts       (dp_sts)
    );

    // an accepted beat takes the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("block not busy after accepting a beat");

    // no memory write while idle
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !(ctl_cmd.t_we || ctl_cmd.d_we))
        else $error("memory write while idle");

    // an answer never overwrites one still waiting
    a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_cmd.out_load |-> (!out_valid || !out_stall))
        else $error("answer loaded over a pending beat");

    // only a query yields an answer
    a_out_only_query: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_cmd.out_load |-> dp_sts.cmd_query)
        else $error("answer produced for an attach");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for tree_lca_binary_lifting: built trees, deep chain, LCA queries.
module testbench;

    localparam int NODES     = 1024;
    localparam int TOP       = 10;
    localparam int LEVELS    = TOP + 1;
    localparam int DEPTH_CAP = 1023;
    localparam int MAX_GAP   = 6;
    localparam int DRAIN     = 200;
    localparam int LIMIT     = 1_000_000;
    localparam int PRINT_CAP = 20;

    typedef logic [lca_pkg::NODE_W-1:0] node_t;
    typedef bit [lca_pkg::DEPTH_W-1:0]  depth_t;

    // One input beat as it goes onto the wires.
    typedef struct {
        logic  cmd;
        node_t a;
        node_t b;
    } lca_beat_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic        command   = lca_pkg::CMD_ATTACH;
    node_t       node_a    = '0;
    node_t       node_b    = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    node_t       ancestor;

    tree_lca_binary_lifting #(
        .MAX_NODES(NODES),
        .TOP_LEVEL(TOP)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .command  (command),
        .node_a   (node_a),
        .node_b   (node_b),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .ancestor (ancestor)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Tree mirror: depth of every node and its 2^i-th ancestor rows, updated
    // in the order the block accepts beats.
    // ------------------------------------------------------------------
    depth_t depth_of [NODES];
    node_t  jump_to  [NODES][LEVELS];

    node_t     expected_ancestors [$];
    lca_beat_t pending_beats [$];

    int attaches    = 0;
    int queries     = 0;
    int answers     = 0;
    int deepest     = 0;
    int saturations = 0;
    int fail_count  = 0;
    int cycles      = 0;

    function automatic void grow_tree(node_t child, node_t parent);
        node_t mid;
        int    lvl;
        if (child == parent)
        begin
            // root: depth zero, every jump lands on itself
            depth_of[child] = '0;
            for (lvl = 0; lvl < LEVELS; lvl++)
                jump_to[child][lvl] = child;
            return;
        end
        if (depth_of[parent] >= DEPTH_CAP)
        begin
            depth_of[child] = depth_t'(DEPTH_CAP);
            saturations++;
        end
        else
            depth_of[child] = depth_of[parent] + depth_t'(1);
        if (int'(depth_of[child]) > deepest)
            deepest = int'(depth_of[child]);
        jump_to[child][0] = parent;
        // rows of the child are filled level by level, reading what was just written
        for (lvl = 1; lvl < LEVELS; lvl++)
        begin
            mid = jump_to[child][lvl-1];
            jump_to[child][lvl] = jump_to[mid][lvl-1];
        end
    endfunction

    function automatic node_t find_lca(node_t a, node_t b);
        node_t lo;
        node_t hi;
        node_t pa;
        node_t pb;
        int    lvl;
        lo = a;
        hi = b;
        if (depth_of[a] > depth_of[b])
        begin
            lo = b;
            hi = a;
        end
        // bring the deeper node up; depth is re-read after every jump
        for (lvl = TOP; lvl >= 0; lvl--)
            if (depth_of[hi] >= depth_of[lo] &&
                int'(depth_of[hi]) - int'(depth_of[lo]) >= (1 << lvl))
                hi = jump_to[hi][lvl];
        if (lo == hi)
            return lo;
        // climb together while the jumps still differ
        for (lvl = TOP; lvl >= 0; lvl--)
        begin
            pa = jump_to[lo][lvl];
            pb = jump_to[hi][lvl];
            if (pa != pb)
            begin
                lo = pa;
                hi = pb;
            end
        end
        return jump_to[lo][0];
    endfunction

    task automatic report_mismatch(string what);
        if (fail_count < PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    // ------------------------------------------------------------------
    // Stimulus bookkeeping. Only nodes already attached are ever named as a
    // parent or in a query, so no unwritten entry is read.
    // ------------------------------------------------------------------
    bit node_known [NODES];
    int known_nodes [$];
    int recent_nodes [$];
    int last_child  = 0;
    int last_parent = 0;

    task automatic queue_beat(logic cmd, int a, int b);
        lca_beat_t beat;
        beat = '{cmd, node_t'(a), node_t'(b)};
        pending_beats.insert(pending_beats.size(), beat);
    endtask

    task automatic queue_attach(int child, int parent);
        queue_beat(lca_pkg::CMD_ATTACH, child, parent);
        if (!node_known[child])
        begin
            node_known[child] = 1'b1;
            known_nodes.insert(known_nodes.size(), child);
        end
        recent_nodes.insert(recent_nodes.size(), child);
        if (recent_nodes.size() > 4)
            void'(recent_nodes.pop_front());
        last_child  = child;
        last_parent = parent;
    endtask

    // recent picks keep growing the same branch so trees get deep
    function automatic int pick_known(bit recent);
        if (recent && recent_nodes.size() > 0)
            return recent_nodes[$urandom_range(0, recent_nodes.size() - 1)];
        return known_nodes[$urandom_range(0, known_nodes.size() - 1)];
    endfunction

    // a node not yet attached; once all are, any node (then it is a re-attach)
    function automatic int pick_fresh();
        int n;
        if (known_nodes.size() == NODES)
            return $urandom_range(0, NODES - 1);
        do
            n = $urandom_range(0, NODES - 1);
        while (node_known[n]);
        return n;
    endfunction

    task automatic mixed_phase(int beats);
        int r;
        int child;
        repeat (beats)
        begin
            r = $urandom_range(0, 99);
            if (known_nodes.size() == 0 || r < 5)
            begin
                // new root, or a re-root once every node exists
                child = pick_fresh();
                queue_attach(child, child);
            end
            else if (r < 45)
                queue_attach(pick_fresh(), pick_known($urandom_range(0, 2) != 0));
            else if (r < 50)
                // noise: move an attached node somewhere else, possibly under itself
                queue_attach(pick_known(1'b0), pick_known(1'b0));
            else if (r < 58)
            begin
                child = pick_known(1'b0);
                queue_beat(lca_pkg::CMD_QUERY, child, child);
            end
            else if (r < 66)
            begin
                if (r[0])
                    queue_beat(lca_pkg::CMD_QUERY, last_child, last_parent);
                else
                    queue_beat(lca_pkg::CMD_QUERY, last_parent, last_child);
            end
            else
                queue_beat(lca_pkg::CMD_QUERY, pick_known(1'($urandom_range(0, 1))),
                           pick_known(1'($urandom_range(0, 1))));
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: offers one beat at a time, holds it while stalled. After each
    // accepted beat it idles for a random gap of up to MAX_GAP; the idle count mostly runs
    // while the block is ready, so gaps also land on idle cycles.
    // ------------------------------------------------------------------
    int        gap_left   = 0;
    bit        send_burst = 1'b0;
    lca_beat_t next_beat;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            command  <= lca_pkg::CMD_ATTACH;
            node_a   <= '0;
            node_b   <= '0;
            gap_left = 0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (in_valid)
            begin
                // beat accepted at this edge
                if (command == lca_pkg::CMD_ATTACH)
                begin
                    grow_tree(node_a, node_b);
                    attaches++;
                end
                else
                begin
                    expected_ancestors.insert(expected_ancestors.size(),
                                              find_lca(node_a, node_b));
                    queries++;
                end
                if ($urandom_range(0, 39) == 0)
                    send_burst = !send_burst;
                gap_left = send_burst ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (gap_left > 0)
            begin
                if (!in_stall || $urandom_range(0, 1) == 1)
                    gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_beats.size() > 0)
            begin
                next_beat = pending_beats.pop_front();
                in_valid  <= 1'b1;
                command   <= next_beat.cmd;
                node_a    <= next_beat.a;
                node_b    <= next_beat.b;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each ancestor beat against the oldest query, then holds
    // stall while a random count of up to MAX_GAP runs down with an answer waiting,
    // so a finished answer sits in the output register while the block takes further beats.
    // ------------------------------------------------------------------
    int    hold_left  = 0;
    bit    recv_burst = 1'b0;
    node_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                answers++;
                if (expected_ancestors.size() == 0)
                    report_mismatch($sformatf("ancestor beat %0d (%0d) with no query outstanding",
                                              answers, ancestor));
                else
                begin
                    want = expected_ancestors.pop_front();
                    if (ancestor !== want)
                        report_mismatch($sformatf("answer %0d: ancestor %0d, expected %0d",
                                                  answers, ancestor, want));
                end
                if ($urandom_range(0, 39) == 0)
                    recv_burst = !recv_burst;
                hold_left = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
            end
            else if (out_valid && hold_left > 0)
                hold_left--;
            out_stall <= (hold_left > 0);
        end
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT)
        begin
            $display("timeout after %0d cycles: %0d beats unsent, %0d answers outstanding",
                     cycles, pending_beats.size(), expected_ancestors.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial
    begin
        int chain [NODES];
        int i;
        int j;
        int t;

        // Directed: extreme node numbers, roots, ancestor and sibling queries,
        // a query across two separate trees, re-attach and re-root.
        queue_attach(0, 0);                 // root at node zero
        queue_attach(1023, 0);
        queue_attach(512, 1023);
        queue_attach(341, 0);
        queue_beat(lca_pkg::CMD_QUERY, 1023, 341);   // siblings under the root
        queue_beat(lca_pkg::CMD_QUERY, 512, 341);    // different depths
        queue_beat(lca_pkg::CMD_QUERY, 512, 1023);   // one is the other's ancestor
        queue_beat(lca_pkg::CMD_QUERY, 0, 0);        // same node
        queue_beat(lca_pkg::CMD_QUERY, 1023, 1023);
        queue_attach(700, 700);             // second tree
        queue_attach(5, 700);
        queue_beat(lca_pkg::CMD_QUERY, 5, 512);      // nodes in different trees
        queue_beat(lca_pkg::CMD_QUERY, 1023, 0);     // deeper node named first
        queue_attach(1023, 700);            // re-attach: 512 keeps its stale row
        queue_beat(lca_pkg::CMD_QUERY, 512, 1023);
        queue_beat(lca_pkg::CMD_QUERY, 1023, 5);
        queue_attach(0, 0);                 // re-root an existing root
        queue_beat(lca_pkg::CMD_QUERY, 512, 0);

        mixed_phase(30);

        // One chain through all nodes in random order: depths 0..1023, so a query can
        // lift at every level below TOP; then attach below the bottom to
        // push depth past its cap.
        for (i = 0; i < NODES; i++)
            chain[i] = i;
        for (i = NODES - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            t        = chain[i];
            chain[i] = chain[j];
            chain[j] = t;
        end
        queue_attach(chain[0], chain[0]);
        for (i = 1; i < NODES; i++)
            queue_attach(chain[i], chain[i-1]);
        queue_beat(lca_pkg::CMD_QUERY, chain[0], chain[NODES-1]);
        queue_beat(lca_pkg::CMD_QUERY, chain[NODES-1], chain[NODES-2]);
        repeat (30)
            queue_beat(lca_pkg::CMD_QUERY, chain[$urandom_range(0, NODES - 1)],
                       chain[$urandom_range(0, NODES - 1)]);
        queue_attach(chain[1], chain[NODES-1]);   // depth saturates
        queue_attach(chain[2], chain[1]);         // and again
        queue_beat(lca_pkg::CMD_QUERY, chain[1], chain[NODES-1]);
        queue_beat(lca_pkg::CMD_QUERY, chain[2], chain[NODES-3]);
        queue_beat(lca_pkg::CMD_QUERY, chain[2], chain[0]);

        mixed_phase(30);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_beats.size() > 0 || in_valid || expected_ancestors.size() > 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("run covered %0d attach and %0d query beats, %0d answers checked",
                 attaches, queries, answers);
        $display("deepest node at depth %0d, %0d capped depths, %0d mismatches",
                 deepest, saturations, fail_count);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
